// ----- design/mae_pkg.sv -----
// Shared types and constants for the median / adaptive EMA / deadband filter.
// Used by mae_median, mae_divider and median_adaptive_ema_deadband_filter.
package mae_pkg;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 17;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BASE_ALPHA   = 3'd0,
    CFG_ALPHA_LIMIT  = 3'd1,
    CFG_ACCEL_THR    = 3'd2,
    CFG_DEADBAND_THR = 3'd3,
    CFG_VALID_LOW    = 3'd4,
    CFG_VALID_HIGH   = 3'd5
  } cfg_reg_e;

  // register field widths
  localparam int ALPHA_W = 17;  // Q0.16 with room for one
  localparam int THR_W   = 15;
  localparam int LIM_W   = 16;

  // register reset values
  localparam logic [ALPHA_W-1:0]      BASE_ALPHA_RST  = 17'd7864;
  localparam logic [ALPHA_W-1:0]      ALPHA_LIMIT_RST = 17'd26214;
  localparam logic [THR_W-1:0]        ACCEL_THR_RST   = 15'd384;
  localparam logic [THR_W-1:0]        DB_THR_RST      = 15'd26;
  localparam logic signed [LIM_W-1:0] VALID_LOW_RST   = -16'sd10240;
  localparam logic signed [LIM_W-1:0] VALID_HIGH_RST  = 16'sd32000;

  // boosted alpha: base * min(err, 3T) / T stays below 3 * 2^17
  localparam int ARAW_W   = 19;
  localparam int SCALE_W  = 17;                 // min(err, 3T) fits here
  localparam int DIVN_W   = ALPHA_W + SCALE_W;  // dividend width
  localparam int DIVQ_W   = ARAW_W;             // quotient width
  localparam int OP_A_W   = ALPHA_W + 1;        // signed multiplier operand A
  localparam int FRAC_W   = 16;

  localparam logic [ARAW_W-1:0] ALPHA_ONE = 19'd65536;

  // median window
  localparam int MED_DEPTH = 3;
  localparam logic [1:0] MED_LAST_SLOT = 2'd2;

endpackage

// ----- design/mae_median.sv -----
// Three-sample median window with pass-through until the window has filled.
// Depends on mae_pkg.
module mae_median import mae_pkg::*; #(
  parameter int SW = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_i,
  input  logic signed [SW-1:0] sample_i,
  output logic signed [SW-1:0] median_o
);

  logic signed [SW-1:0] win_q [MED_DEPTH];
  logic [1:0]           slot_q;
  logic                 full_q;
  logic                 full_d;
  logic signed [SW-1:0] n0, n1, n2;
  logic signed [SW-1:0] med_q;

  function automatic logic signed [SW-1:0] med3(input logic signed [SW-1:0] a,
                                                input logic signed [SW-1:0] b,
                                                input logic signed [SW-1:0] c);
    logic signed [SW-1:0] lo, hi, m;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    m  = (hi < c) ? hi : c;
    return (lo > m) ? lo : m;
  endfunction

  // window contents as they stand after this write
  assign n0 = (slot_q == 2'd0) ? sample_i : win_q[0];
  assign n1 = (slot_q == 2'd1) ? sample_i : win_q[1];
  assign n2 = (slot_q == MED_LAST_SLOT) ? sample_i : win_q[2];
  assign full_d = full_q | (slot_q == MED_LAST_SLOT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      full_q <= 1'b0;
    end else if (wr_i) begin
      slot_q <= (slot_q == MED_LAST_SLOT) ? 2'd0 : slot_q + 2'd1;
      full_q <= full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i) begin
      win_q[slot_q] <= sample_i;
      med_q         <= full_d ? med3(n0, n1, n2) : sample_i;
    end
  end

  assign median_o = med_q;

endmodule

// ----- design/mae_divider.sv -----
// Restoring divider, one quotient bit per cycle, for the boosted alpha.
// Quotient must fit DIVQ_W bits. Depends on mae_pkg.
module mae_divider import mae_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIVN_W-1:0] dividend_i,
  input  logic [THR_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [DIVQ_W-1:0] quot_o
);

  localparam int CNT_W = $clog2(DIVQ_W + 1);

  logic [THR_W-1:0]  rem_q;
  logic [THR_W-1:0]  den_q;
  logic [DIVQ_W-1:0] num_q;
  logic [DIVQ_W-1:0] quot_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              busy_q;
  logic              done_q;
  logic [THR_W:0]    trial;
  logic              ge;

  assign trial = {rem_q, num_q[DIVQ_W-1]};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVQ_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // upper bits already sit below the divisor since the quotient fits
      rem_q  <= dividend_i[DIVN_W-1 -: THR_W];
      num_q  <= dividend_i[DIVQ_W-1:0];
      den_q  <= divisor_i;
      quot_q <= '0;
    end else if (busy_q) begin
      rem_q  <= ge ? THR_W'(trial - {1'b0, den_q}) : trial[THR_W-1:0];
      num_q  <= {num_q[DIVQ_W-2:0], 1'b0};
      quot_q <= {quot_q[DIVQ_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

// ----- design/median_adaptive_ema_deadband_filter.sv -----
// Median / adaptive EMA / deadband filter for one sensor channel.
// Depends on mae_pkg, mae_median and mae_divider.
//
// Usage: samples enter on in_valid_i/in_ready_o, one transaction per sample.
// Each sample yields one result on out_valid_o/out_ready_i: the held value,
// whether the sample lay inside [valid_low, valid_high], and whether any
// sample has been filtered yet. Configuration registers are written through
// cfg_valid_i/cfg_index_i/cfg_data_i; the user must write them only while the
// filter is idle, which the block itself does not enforce. cfg_ready_o is
// always high. Index 0..5: base alpha, alpha limit, accel threshold, deadband
// threshold, valid low, valid high. A rejected sample goes straight to
// ST_OUT; the first accepted one passes ST_EMA and ST_HOLD; later ones pass
// ST_EMA, ST_ALPHA, ST_CLAMP, ST_MUL, ST_APPLY and ST_HOLD, and with boost and
// a nonzero threshold also wait in ST_DIV_WAIT on the bit-serial divider.
// All multiplies go through one shared registered multiplier. in_ready_o is
// high only while the sequencer idles, so one sample is in flight at a time.
// The result sits in an output register: a stalled receiver does not block
// the next sample, but a second result waits until the first is taken.
// Reset clears all filter state and loads the default register values.
module median_adaptive_ema_deadband_filter import mae_pkg::*; #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]           cfg_index_i,
  input  logic [CFG_DATA_W-1:0]          cfg_data_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic signed [SAMPLE_WIDTH-1:0] held_value_o,
  output logic                           sample_ok_o,
  output logic                           has_value_o
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int XW = (SW > LIM_W) ? SW : LIM_W;
  localparam int DW = SW + 1;
  localparam int EW = (DW > SCALE_W) ? DW : SCALE_W;
  localparam int MW = (DW > OP_A_W) ? DW : OP_A_W;
  localparam int PW = OP_A_W + MW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EMA, ST_ALPHA, ST_DIV_LOAD, ST_DIV_WAIT,
    ST_CLAMP, ST_MUL, ST_APPLY, ST_HOLD, ST_OUT
  } state_e;

  state_e state_q;

  // configuration registers
  logic [ALPHA_W-1:0]      base_alpha_q, alpha_limit_q;
  logic [THR_W-1:0]        accel_thr_q, db_thr_q;
  logic signed [LIM_W-1:0] valid_low_q, valid_high_q;

  // filter state
  logic signed [SW-1:0] smoothed_q;
  logic                 smooth_started_q;
  logic signed [SW-1:0] last_held_q;
  logic                 hold_started_q;

  // working registers
  logic                 ok_q;
  logic signed [DW-1:0] diff_q;
  logic [DW-1:0]        err_q;
  logic [ARAW_W-1:0]    alpha_q;
  logic                 boosted_q;
  logic signed [PW-1:0] prod_q;

  // output register
  logic                 out_valid_q;
  logic signed [SW-1:0] held_q;
  logic                 sample_ok_q;
  logic                 has_value_q;

  logic                 in_acc;
  logic signed [XW-1:0] x_ext;
  logic                 in_range;
  logic signed [SW-1:0] median;
  logic signed [DW-1:0] diff_d;
  logic [DW-1:0]        err_d;
  logic [EW-1:0]        err_ext;
  logic [SCALE_W-1:0]   thr3;
  logic [SCALE_W-1:0]   scale;
  logic                 boost;
  logic [ARAW_W-1:0]    base3;
  logic [ARAW_W-1:0]    alpha_lim;
  logic [ARAW_W-1:0]    alpha_sat;
  logic signed [DW-1:0] step;
  logic signed [DW-1:0] hold_diff;
  logic [DW-1:0]        hold_abs;
  logic                 hold_upd;
  logic signed [OP_A_W-1:0] op_a;
  logic signed [MW-1:0]     op_b;
  logic                 div_start;
  logic                 div_done;
  logic [DIVQ_W-1:0]    div_quot;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_acc      = in_valid_i & in_ready_o;

  assign x_ext    = XW'(sample_i);
  assign in_range = (x_ext >= XW'(valid_low_q)) && (x_ext <= XW'(valid_high_q));

  mae_median #(.SW(SW)) u_median (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_i     (in_acc & in_range),
    .sample_i (sample_i),
    .median_o (median)
  );

  // error against the running average
  assign diff_d = DW'(median) - DW'(smoothed_q);
  assign err_d  = diff_d[DW-1] ? DW'(-diff_d) : DW'(diff_d);

  // alpha boost decision
  assign err_ext = EW'(err_q);
  assign thr3    = SCALE_W'({2'b00, accel_thr_q}) + SCALE_W'({1'b0, accel_thr_q, 1'b0});
  assign boost   = err_ext > EW'(accel_thr_q);
  assign scale   = (err_ext > EW'(thr3)) ? thr3 : err_ext[SCALE_W-1:0];
  assign base3   = ARAW_W'({2'b00, base_alpha_q}) + ARAW_W'({1'b0, base_alpha_q, 1'b0});
  assign alpha_lim = (boosted_q && (alpha_q > ARAW_W'(alpha_limit_q))) ?
                     ARAW_W'(alpha_limit_q) : alpha_q;
  assign alpha_sat = (alpha_lim > ALPHA_ONE) ? ALPHA_ONE : alpha_lim;

  // shared multiplier: base * scale for the boost, alpha * error for the update
  always_comb begin
    if (state_q == ST_ALPHA) begin
      op_a = $signed({1'b0, base_alpha_q});
      op_b = MW'($signed({1'b0, scale}));
    end else begin
      op_a = $signed({1'b0, alpha_q[ALPHA_W-1:0]});
      op_b = MW'(diff_q);
    end
  end

  assign step = DW'(prod_q >>> FRAC_W);

  // deadband
  assign hold_diff = DW'(smoothed_q) - DW'(last_held_q);
  assign hold_abs  = hold_diff[DW-1] ? DW'(-hold_diff) : DW'(hold_diff);
  assign hold_upd  = !hold_started_q || (EW'(hold_abs) >= EW'(db_thr_q));

  assign div_start = (state_q == ST_DIV_LOAD);

  mae_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (prod_q[DIVN_W-1:0]),
    .divisor_i  (accel_thr_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i) begin
    prod_q <= PW'(op_a) * PW'(op_b);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_alpha_q  <= BASE_ALPHA_RST;
      alpha_limit_q <= ALPHA_LIMIT_RST;
      accel_thr_q   <= ACCEL_THR_RST;
      db_thr_q      <= DB_THR_RST;
      valid_low_q   <= VALID_LOW_RST;
      valid_high_q  <= VALID_HIGH_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_BASE_ALPHA:   base_alpha_q  <= cfg_data_i;
        CFG_ALPHA_LIMIT:  alpha_limit_q <= cfg_data_i;
        CFG_ACCEL_THR:    accel_thr_q   <= cfg_data_i[THR_W-1:0];
        CFG_DEADBAND_THR: db_thr_q      <= cfg_data_i[THR_W-1:0];
        CFG_VALID_LOW:    valid_low_q   <= $signed(cfg_data_i[LIM_W-1:0]);
        CFG_VALID_HIGH:   valid_high_q  <= $signed(cfg_data_i[LIM_W-1:0]);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q          <= ST_IDLE;
      smoothed_q       <= '0;
      smooth_started_q <= 1'b0;
      last_held_q      <= '0;
      hold_started_q   <= 1'b0;
      ok_q             <= 1'b0;
      diff_q           <= '0;
      err_q            <= '0;
      alpha_q          <= '0;
      boosted_q        <= 1'b0;
      out_valid_q      <= 1'b0;
      held_q           <= '0;
      sample_ok_q      <= 1'b0;
      has_value_q      <= 1'b0;
    end else begin
      // ST_OUT reloads the output register itself
      if (out_ready_i && (state_q != ST_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            ok_q    <= in_range;
            state_q <= in_range ? ST_EMA : ST_OUT;
          end
        end
        ST_EMA: begin
          if (!smooth_started_q) begin
            smoothed_q       <= median;
            smooth_started_q <= 1'b1;
            state_q          <= ST_HOLD;
          end else begin
            diff_q  <= diff_d;
            err_q   <= err_d;
            state_q <= ST_ALPHA;
          end
        end
        ST_ALPHA: begin
          boosted_q <= boost;
          if (!boost) begin
            alpha_q <= ARAW_W'(base_alpha_q);
            state_q <= ST_CLAMP;
          end else if (accel_thr_q == '0) begin
            // zero threshold: scale saturates at three
            alpha_q <= base3;
            state_q <= ST_CLAMP;
          end else begin
            state_q <= ST_DIV_LOAD;
          end
        end
        ST_DIV_LOAD: begin
          state_q <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            alpha_q <= div_quot;
            state_q <= ST_CLAMP;
          end
        end
        ST_CLAMP: begin
          alpha_q <= alpha_sat;
          state_q <= ST_MUL;
        end
        ST_MUL: begin
          state_q <= ST_APPLY;
        end
        ST_APPLY: begin
          // v + floor(alpha * (x - v) / 2^16) stays between x and v
          smoothed_q <= SW'(DW'(smoothed_q) + step);
          state_q    <= ST_HOLD;
        end
        ST_HOLD: begin
          if (hold_upd) begin
            last_held_q <= smoothed_q;
          end
          hold_started_q <= 1'b1;
          state_q        <= ST_OUT;
        end
        ST_OUT: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            held_q      <= last_held_q;
            sample_ok_q <= ok_q;
            has_value_q <= hold_started_q;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign held_value_o = held_q;
  assign sample_ok_o  = sample_ok_q;
  assign has_value_o  = has_value_q;

endmodule
